/* hdl/ordered_list_engine_assert.svh */
// Assertion macros for the ordered list engine.
// Uses the clk_i and rst_ni ports of the module that includes it.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define OLE_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define OLE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ole_pkg.sv */
// Shared constants, codes and types for the ordered list engine.
// No dependencies; used by ole_cell and ordered_list_engine.
`default_nettype none

package ole_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned GRP    = 8;
  localparam int unsigned GRP_W  = $clog2(GRP);
  localparam int unsigned NGRP   = DEPTH / GRP;
  localparam int unsigned NGRP_W = $clog2(NGRP);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4,
    CMD_LOCATE = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_CLAMPED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_FROM_LOWER = 2'd2,
    OP_FROM_UPPER = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     chk;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/ordered_list_engine.sv */
// Ordered list engine: top level with the cell row, command decode and result register.
// Depends on ole_pkg, ole_cell and ordered_list_engine_assert.svh.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one command word:
//   command_i, index_i, value_i. Every command yields exactly one result
//   word on the output channel (out_valid_o / out_ready_i): read_value_o,
//   position_o, found_o, length_o, status_o.
//   Timing: push, pop, insert, delete, read, clear and unused codes update
//   the cell row and load the result register at the accepting edge.
//   Locate: match flags are registered at acceptance,
//   then a group priority stage, then the final group pick loads the result.
//   Throughput: one command per cycle while the receiver takes results, for
//   all commands but locate, which occupies the engine until its two-stage
//   priority encoder over the match flags is done.
//   Reset empties the list (length zero); stored words are not cleared.
//   When the receiver stalls, the result register holds its word and the
//   engine takes no new command until that word is taken (a command may be
//   taken in the same cycle as the pending result).
`default_nettype none

module ordered_list_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ole_pkg::CMD_W-1:0]     command_i,
  input  wire logic [ole_pkg::IDX_W-1:0]     index_i,
  input  wire logic [ole_pkg::DATA_W-1:0]    value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [ole_pkg::DATA_W-1:0]    read_value_o,
  output logic      [ole_pkg::IDX_W-1:0]     position_o,
  output logic                               found_o,
  output logic      [ole_pkg::CNT_W-1:0]     length_o,
  output logic      [ole_pkg::ST_W-1:0]      status_o
);

  localparam int unsigned DEPTH  = ole_pkg::DEPTH;
  localparam int unsigned DATA_W = ole_pkg::DATA_W;
  localparam int unsigned IDX_W  = ole_pkg::IDX_W;
  localparam int unsigned CNT_W  = ole_pkg::CNT_W;
  localparam int unsigned GRP    = ole_pkg::GRP;
  localparam int unsigned GRP_W  = ole_pkg::GRP_W;
  localparam int unsigned NGRP   = ole_pkg::NGRP;
  localparam int unsigned NGRP_W = ole_pkg::NGRP_W;

  // Engine sequencer: idle, or one of the two locate encode steps.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_GROUP = 3'b010,
    S_FINAL = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;

  // Result register.
  logic [DATA_W-1:0]    rd_q, rd_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic                 found_q, found_d;
  logic [CNT_W-1:0]     len_q, len_d;
  ole_pkg::status_e     st_q, st_d;
  logic                 load_out;

  // Locate pipeline.
  logic [DEPTH-1:0]     match_q;
  logic [NGRP-1:0]      grp_any_q, grp_any_d;
  logic [GRP_W-1:0]     grp_pos_q [NGRP];
  logic [GRP_W-1:0]     grp_pos_d [NGRP];

  // Cell row.
  ole_pkg::cell_ctrl_t  ctrl [DEPTH];
  logic [DATA_W-1:0]    word [DEPTH];
  logic [DEPTH-1:0]     match;

  logic             in_fire;
  ole_pkg::cmd_e    cmd;
  logic             full, empty;
  logic [CNT_W-1:0] idx_ext;
  logic             idx_past;   // index at or past the length
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_word;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cmd        = ole_pkg::cmd_e'(command_i);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign idx_ext    = {1'b0, index_i};
  assign idx_past   = (idx_ext >= count_q);
  assign last_idx   = IDX_W'(count_q - CNT_W'(1));

  // Per-cell control: where each cell takes its next word from.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].chk = (CNT_W'(i) < count_q);
      ctrl[i].op  = ole_pkg::OP_HOLD;
      if (in_fire) begin
        case (cmd)
          ole_pkg::CMD_PUSH: begin
            if (!full && (CNT_W'(i) == count_q)) ctrl[i].op = ole_pkg::OP_LOAD;
          end
          ole_pkg::CMD_INSERT: begin
            if (!full) begin
              if (idx_past) begin
                if (CNT_W'(i) == count_q) ctrl[i].op = ole_pkg::OP_LOAD;
              end else if (CNT_W'(i) == idx_ext) begin
                ctrl[i].op = ole_pkg::OP_LOAD;
              end else if ((CNT_W'(i) > idx_ext) && (CNT_W'(i) <= count_q)) begin
                ctrl[i].op = ole_pkg::OP_FROM_LOWER;
              end
            end
          end
          ole_pkg::CMD_DELETE: begin
            // Close the gap: entries from index up to the last move down.
            if (!empty && (CNT_W'(i) >= idx_ext) && (CNT_W'(i + 1) < count_q)) begin
              ctrl[i].op = ole_pkg::OP_FROM_UPPER;
            end
          end
          default: ctrl[i].op = ole_pkg::OP_HOLD;
        endcase
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = word[g+1];
    end
    ole_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .lower_i (lower),
      .upper_i (upper),
      .value_i (value_i),
      .word_o  (word[g]),
      .match_o (match[g])
    );
  end

  // Read port: pop takes the last entry, read clamps to the last entry.
  always_comb begin
    rd_addr = index_i;
    if ((cmd == ole_pkg::CMD_POP) || idx_past) rd_addr = last_idx;
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | (word[i] & {DATA_W{rd_addr == IDX_W'(i)}});
    end
  end

  // Locate, first step: lowest match inside each group of cells.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_d[g] = |match_q[g*GRP +: GRP];
      grp_pos_d[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (match_q[g*GRP + j]) grp_pos_d[g] = GRP_W'(j);
      end
    end
  end

  // Command decode, result build and sequencer.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    load_out = 1'b0;
    rd_d     = '0;
    pos_d    = '0;
    found_d  = 1'b0;
    st_d     = ole_pkg::ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          case (cmd)
            ole_pkg::CMD_PUSH, ole_pkg::CMD_INSERT: begin
              if (full) st_d = ole_pkg::ST_FULL;
              else      count_d = count_q + CNT_W'(1);
            end
            ole_pkg::CMD_POP: begin
              if (empty) begin
                rd_d = '1;
                st_d = ole_pkg::ST_EMPTY;
              end else begin
                rd_d    = rd_word;
                count_d = count_q - CNT_W'(1);
              end
            end
            ole_pkg::CMD_DELETE: begin
              if (empty) st_d = ole_pkg::ST_EMPTY;
              else       count_d = count_q - CNT_W'(1);
            end
            ole_pkg::CMD_READ: begin
              if (empty) begin
                st_d = ole_pkg::ST_EMPTY;
              end else begin
                rd_d = rd_word;
                if (idx_past) st_d = ole_pkg::ST_CLAMPED;
              end
            end
            ole_pkg::CMD_LOCATE: begin
              // Hold the result back until the encoder is done.
              load_out = 1'b0;
              state_d  = S_GROUP;
            end
            ole_pkg::CMD_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      S_GROUP: state_d = S_FINAL;
      S_FINAL: begin
        load_out = 1'b1;
        state_d  = S_IDLE;
        if (empty) st_d = ole_pkg::ST_EMPTY;
        for (int g = NGRP - 1; g >= 0; g--) begin
          if (grp_any_q[g]) begin
            found_d = 1'b1;
            pos_d   = {NGRP_W'(g), grp_pos_q[g]};
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    len_d       = count_d;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rd_q    <= rd_d;
      pos_q   <= pos_d;
      found_q <= found_d;
      len_q   <= len_d;
      st_q    <= st_d;
    end
    if (in_fire) match_q <= match;
    grp_any_q <= grp_any_d;
    grp_pos_q <= grp_pos_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rd_q;
  assign position_o   = pos_q;
  assign found_o      = found_q;
  assign length_o     = len_q;
  assign status_o     = st_q;

  `include "ordered_list_engine_assert.svh"

  `OLE_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "list length exceeds depth")
  `OLE_ASSERT_NEXT(a_push_grows, in_fire && (cmd == ole_pkg::CMD_PUSH) && !full, count_q == $past(count_q) + CNT_W'(1), "accepted push did not grow the list")
  `OLE_ASSERT_SAME(a_found_sane, out_valid_o && found_o, (status_o == ole_pkg::ST_OK) && ({1'b0, position_o} < length_o), "locate hit outside the list")

endmodule

`default_nettype wire

/* hdl/ole_cell.sv */
// One storage cell of the ordered list: holds one word, shifts with its neighbors.
// Depends on ole_pkg.
`default_nettype none

module ole_cell (
  input  wire logic                        clk_i,
  input  wire ole_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic [ole_pkg::DATA_W-1:0]  lower_i,
  input  wire logic [ole_pkg::DATA_W-1:0]  upper_i,
  input  wire logic [ole_pkg::DATA_W-1:0]  value_i,
  output logic      [ole_pkg::DATA_W-1:0]  word_o,
  output logic                             match_o
);

  logic [ole_pkg::DATA_W-1:0] word_q, word_d;

  always_comb begin
    case (ctrl_i.op)
      ole_pkg::OP_LOAD:       word_d = value_i;
      ole_pkg::OP_FROM_LOWER: word_d = lower_i;
      ole_pkg::OP_FROM_UPPER: word_d = upper_i;
      default:                word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o  = word_q;
  assign match_o = ctrl_i.chk && (word_q == value_i);

endmodule

`default_nettype wire
